[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the 2-D affine accumulator.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ATA2D_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ata2d assertion failed");

// next-cycle implication
`define ATA2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ata2d assertion failed");

`endif

[hw/rtl/ata2d_pkg.sv]
// Types and constants of the 2-D affine transform accumulator.
// Used by the sin/cos, multiply-accumulate, top and checker files; depends on nothing.
`default_nettype none
package ata2d_pkg;

   typedef enum logic [2:0] {
      CMD_IDENTITY  = 3'd0,
      CMD_LOAD_ROW  = 3'd1,
      CMD_ROTATE    = 3'd2,
      CMD_TRANSLATE = 3'd3,
      CMD_SHEAR     = 3'd4,
      CMD_SCALE     = 3'd5,
      CMD_TRANSFORM = 3'd6,
      CMD_READ_ROW  = 3'd7
   } cmd_type;

   localparam logic [1:0]         RowNone     = 2'd3;
   localparam logic [4:0]         CordicLast  = 5'd29;
   localparam logic signed [33:0] CordicGain  = 34'sd652032874;

   typedef struct packed {
      logic mul;
      logic acc;
      logic first;
   } mac_ctrl_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000029;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/ata2d_if.sv]
// Valid/ready channels of the 2-D affine accumulator: request and response words.
// Depends on nothing.
`default_nettype none
interface ata2d_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic [1:0]        row_sel;
   logic signed [31:0] value_a;
   logic signed [31:0] value_b;
   logic signed [31:0] value_c;
   modport source (output valid, cmd, row_sel, value_a, value_b, value_c, input ready);
   modport sink   (input valid, cmd, row_sel, value_a, value_b, value_c, output ready);
endinterface

interface ata2d_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] out_a;
   logic signed [31:0] out_b;
   logic signed [31:0] out_c;
   logic              overflow;
   modport source (output valid, out_a, out_b, out_c, overflow, input ready);
   modport sink   (input valid, out_a, out_b, out_c, overflow, output ready);
endinterface
`default_nettype wire

[hw/rtl/ata2d_sincos.sv]
// Angle unit: reciprocal-multiply conversion of degrees to a binary angle, then 30 CORDIC
// rotations. Depends on ata2d_pkg.
`default_nettype none
module ata2d_sincos #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] deg,
   output logic               done,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);
   localparam int Sh = 29 - FRAC_BITS;
   localparam logic [32:0] Recip45   = 33'd6108397933;
   localparam logic [27:0] Recip45Lo = 28'd190887436;
   localparam logic signed [33:0] Half = 34'sd1 <<< (29 - FRAC_BITS);

   typedef enum logic [2:0] {S_IDLE, S_RECIP, S_REM, S_FRAC, S_ANG, S_ROT, S_DONE}
      state_type;

   state_type          state_ff;
   logic [31:0]        mag_ff;
   logic               neg_ff;
   logic [26:0]        q1_ff;
   logic [5:0]         rem_ff;
   logic [31:0]        quo_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [4:0]         iter_ff;
   logic               flip_ff;
   logic               done_ff;
   logic signed [31:0] sin_ff, cos_ff;

   logic [31:0]        mag;
   logic [64:0]        prod_hi;
   logic [31:0]        prod45, rem_full;
   logic [26:0]        scaled;
   logic [54:0]        prod_lo;
   logic [31:0]        quo_in;
   logic [31:0]        ba, wrap, bz;
   logic signed [33:0] xs, ys, at, xr, yr;

   always_comb begin
      mag      = deg[31] ? (~deg + 32'd1) : deg;
      prod_hi  = {33'b0, mag_ff} * {32'b0, Recip45};
      prod45   = {5'b0, q1_ff} * 32'd45;
      rem_full = mag_ff - prod45;
      scaled   = {21'b0, rem_ff} << Sh;
      prod_lo  = {28'b0, scaled} * {27'b0, Recip45Lo};
      quo_in   = ({5'b0, q1_ff} << Sh) + {10'b0, prod_lo[54:33]};
      ba       = neg_ff ? (~quo_ff + 32'd1) : quo_ff;
      wrap     = ba + 32'h4000_0000;
      bz       = wrap[31] ? (ba ^ 32'h8000_0000) : ba;
      xs       = x_ff >>> iter_ff;
      ys       = y_ff >>> iter_ff;
      at       = signed'({4'b0, ata2d_pkg::atan_entry(iter_ff)});
      xr       = (x_ff + Half) >>> (30 - FRAC_BITS);
      yr       = (y_ff + Half) >>> (30 - FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mag_ff   <= mag;
                  neg_ff   <= deg[31];
                  state_ff <= S_RECIP;
               end
            end
            S_RECIP: begin
               q1_ff    <= prod_hi[64:38];
               state_ff <= S_REM;
            end
            S_REM: begin
               rem_ff   <= rem_full[5:0];
               state_ff <= S_FRAC;
            end
            S_FRAC: begin
               quo_ff   <= quo_in;
               state_ff <= S_ANG;
            end
            S_ANG: begin
               flip_ff  <= wrap[31];
               z_ff     <= 34'(signed'(bz));
               x_ff     <= ata2d_pkg::CordicGain;
               y_ff     <= '0;
               iter_ff  <= '0;
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (!z_ff[33]) begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - at;
               end else begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + at;
               end
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == ata2d_pkg::CordicLast) state_ff <= S_DONE;
            end
            S_DONE: begin
               cos_ff   <= flip_ff ? -xr[31:0] : xr[31:0];
               sin_ff   <= flip_ff ? -yr[31:0] : yr[31:0];
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule
`default_nettype wire

[hw/rtl/ata2d_mac.sv]
// Shared multiply-accumulate with round-to-nearest and 32-bit saturation.
// Depends on ata2d_pkg.
`default_nettype none
module ata2d_mac #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  ata2d_pkg::mac_ctrl_type ctrl,
   input  logic signed [31:0]     op_a,
   input  logic signed [31:0]     op_b,
   output logic signed [31:0]     result,
   output logic                   saturated
);
   localparam logic signed [65:0] Half = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] MaxV = 66'sd2147483647;
   localparam logic signed [65:0] MinV = -66'sd2147483648;

   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic signed [65:0] rnd;

   always_ff @(posedge clock) begin
      if (ctrl.mul) prod_ff <= 64'(op_a) * 64'(op_b);
      if (ctrl.acc) acc_ff  <= ctrl.first ? 66'(prod_ff) : acc_ff + 66'(prod_ff);
   end

   always_comb begin
      rnd = (acc_ff + Half) >>> FRAC_BITS;
      saturated = 1'b0;
      if (rnd > MaxV) begin
         result    = 32'sh7FFF_FFFF;
         saturated = 1'b1;
      end else if (rnd < MinV) begin
         result    = 32'sh8000_0000;
         saturated = 1'b1;
      end else begin
         result = rnd[31:0];
      end
   end
endmodule
`default_nettype wire

[hw/rtl/affine_transform_accumulator_2d_top.sv]
// Identity, load row and read row answer in the cycle after the word is taken.
// Transform vector, translate, shear and scale use one shared multiply-accumulate:
// multiply and accumulate step per product, three (transform vector) or nine element
// stores, one commit. Rotate adds reciprocal angle conversion and 30 CORDIC steps.
// One word at a time: ready stays low until the response word is taken.
// Synchronous reset loads the identity matrix and empties the response register.
`default_nettype none
module affine_transform_accumulator_2d_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   ata2d_req_if.sink    req_chan,
   ata2d_rsp_if.source  rsp_chan
);
   localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [2:0] {ST_IDLE, ST_ANGLE, ST_MUL, ST_ACC, ST_STORE, ST_COMMIT}
      state_type;

   state_type          state_ff;
   ata2d_pkg::cmd_type cmd_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, sin_ff, cos_ff;
   logic [1:0]         i_ff, j_ff, k_ff;
   logic signed [31:0] m_ff [9];
   logic signed [31:0] r_ff [9];
   logic               ovf_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] out_a_ff, out_b_ff, out_c_ff;
   logic               out_ovf_ff;

   logic               req_ready, accept, is_xform;
   ata2d_pkg::cmd_type req_cmd;
   logic [3:0]         maddr, ridx, rbase;
   logic [1:0]         last_j;
   logic signed [31:0] e_val, m_rd, vec_k, op_a, op_b, mac_res;
   logic               mac_sat, sc_done;
   logic signed [31:0] sc_sin, sc_cos;
   ata2d_pkg::mac_ctrl_type mac_ctrl;

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
      accept    = req_chan.valid && req_ready;
      req_cmd   = ata2d_pkg::cmd_type'(req_chan.cmd);
      is_xform  = cmd_ff == ata2d_pkg::CMD_TRANSFORM;
      maddr     = is_xform ? ({2'b0, i_ff} * 4'd3 + {2'b0, k_ff})
                           : ({2'b0, k_ff} * 4'd3 + {2'b0, j_ff});
      ridx      = {2'b0, i_ff} * 4'd3 + {2'b0, j_ff};
      rbase     = {2'b0, req_chan.row_sel} * 4'd3;
      last_j    = is_xform ? 2'd0 : 2'd2;
      m_rd      = m_ff[maddr];
      unique case (k_ff)
         2'd0:    vec_k = a_ff;
         2'd1:    vec_k = b_ff;
         default: vec_k = c_ff;
      endcase
      e_val = (i_ff == k_ff) ? One : 32'sd0;
      unique case (cmd_ff)
         ata2d_pkg::CMD_ROTATE: begin
            if (i_ff == k_ff && i_ff != 2'd2)      e_val = cos_ff;
            else if (i_ff == 2'd0 && k_ff == 2'd1) e_val = -sin_ff;
            else if (i_ff == 2'd1 && k_ff == 2'd0) e_val = sin_ff;
         end
         ata2d_pkg::CMD_TRANSLATE: begin
            if (i_ff == 2'd0 && k_ff == 2'd2)      e_val = a_ff;
            else if (i_ff == 2'd1 && k_ff == 2'd2) e_val = b_ff;
         end
         ata2d_pkg::CMD_SHEAR: begin
            if (i_ff == 2'd0 && k_ff == 2'd1)      e_val = a_ff;
            else if (i_ff == 2'd1 && k_ff == 2'd0) e_val = b_ff;
         end
         ata2d_pkg::CMD_SCALE: begin
            if (i_ff == 2'd0 && k_ff == 2'd0)      e_val = a_ff;
            else if (i_ff == 2'd1 && k_ff == 2'd1) e_val = b_ff;
         end
         default: ;
      endcase
      op_a           = is_xform ? m_rd : e_val;
      op_b           = is_xform ? vec_k : m_rd;
      mac_ctrl.mul   = state_ff == ST_MUL;
      mac_ctrl.acc   = state_ff == ST_ACC;
      mac_ctrl.first = k_ff == 2'd0;
   end

   ata2d_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && req_cmd == ata2d_pkg::CMD_ROTATE),
      .deg     (req_chan.value_a),
      .done    (sc_done),
      .sin_out (sc_sin),
      .cos_out (sc_cos)
   );

   ata2d_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .op_a      (op_a),
      .op_b      (op_b),
      .result    (mac_res),
      .saturated (mac_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 9; n++) m_ff[n] <= (n % 4 == 0) ? One : 32'sd0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff     <= req_cmd;
                  a_ff       <= req_chan.value_a;
                  b_ff       <= req_chan.value_b;
                  c_ff       <= req_chan.value_c;
                  i_ff       <= 2'd0;
                  j_ff       <= 2'd0;
                  k_ff       <= 2'd0;
                  ovf_ff     <= 1'b0;
                  out_a_ff   <= '0;
                  out_b_ff   <= '0;
                  out_c_ff   <= '0;
                  out_ovf_ff <= 1'b0;
                  unique case (req_cmd)
                     ata2d_pkg::CMD_IDENTITY: begin
                        for (int n = 0; n < 9; n++) m_ff[n] <= (n % 4 == 0) ? One : 32'sd0;
                        rsp_valid_ff <= 1'b1;
                     end
                     ata2d_pkg::CMD_LOAD_ROW: begin
                        if (req_chan.row_sel != ata2d_pkg::RowNone) begin
                           m_ff[rbase]         <= req_chan.value_a;
                           m_ff[rbase + 4'd1]  <= req_chan.value_b;
                           m_ff[rbase + 4'd2]  <= req_chan.value_c;
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     ata2d_pkg::CMD_READ_ROW: begin
                        if (req_chan.row_sel != ata2d_pkg::RowNone) begin
                           out_a_ff <= m_ff[rbase];
                           out_b_ff <= m_ff[rbase + 4'd1];
                           out_c_ff <= m_ff[rbase + 4'd2];
                        end
                        rsp_valid_ff <= 1'b1;
                     end
                     ata2d_pkg::CMD_ROTATE: state_ff <= ST_ANGLE;
                     default:               state_ff <= ST_MUL;
                  endcase
               end
            end
            ST_ANGLE: begin
               if (sc_done) begin
                  sin_ff   <= sc_sin;
                  cos_ff   <= sc_cos;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_ACC;
            ST_ACC: begin
               if (k_ff == 2'd2) begin
                  state_ff <= ST_STORE;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_STORE: begin
               r_ff[ridx] <= mac_res;
               ovf_ff     <= ovf_ff | mac_sat;
               k_ff       <= 2'd0;
               state_ff   <= ST_MUL;
               if (j_ff == last_j) begin
                  j_ff <= 2'd0;
                  if (i_ff == 2'd2) state_ff <= ST_COMMIT;
                  else              i_ff     <= i_ff + 2'd1;
               end else begin
                  j_ff <= j_ff + 2'd1;
               end
            end
            ST_COMMIT: begin
               if (is_xform) begin
                  out_a_ff <= r_ff[0];
                  out_b_ff <= r_ff[3];
                  out_c_ff <= r_ff[6];
               end else begin
                  for (int n = 0; n < 9; n++) m_ff[n] <= r_ff[n];
               end
               out_ovf_ff   <= ovf_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready    = req_ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_a    = out_a_ff;
   assign rsp_chan.out_b    = out_b_ff;
   assign rsp_chan.out_c    = out_c_ff;
   assign rsp_chan.overflow = out_ovf_ff;
endmodule
`default_nettype wire

[hw/rtl/ata2d_checker.sv]
// Port-level checks on the 2-D affine accumulator, bound to its top level.
// Depends on ata2d_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ata2d_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_cmd,
   input logic [1:0]  req_row_sel,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_a,
   input logic [31:0] rsp_out_b,
   input logic [31:0] rsp_out_c,
   input logic        rsp_overflow
);
   logic take, quick;

   assign take  = req_valid && req_ready;
   assign quick = req_cmd == ata2d_pkg::CMD_IDENTITY || req_cmd == ata2d_pkg::CMD_LOAD_ROW
               || req_cmd == ata2d_pkg::CMD_READ_ROW;

   `ATA2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ATA2D_ASSERT_NEXT(a_busy_after_take, clock, reset, take, !req_ready)
   `ATA2D_ASSERT_NEXT(a_quick_answer, clock, reset, take && quick, rsp_valid && !rsp_overflow)
   `ATA2D_ASSERT_NEXT(a_row_none_zero, clock, reset,
      take && req_cmd == ata2d_pkg::CMD_READ_ROW && req_row_sel == ata2d_pkg::RowNone,
      rsp_out_a == 32'd0 && rsp_out_b == 32'd0 && rsp_out_c == 32'd0)
   `ATA2D_ASSERT_NOW(a_no_take_while_full, clock, reset, rsp_valid, !req_ready)
endmodule

bind affine_transform_accumulator_2d_top ata2d_port_props u_port_props (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_cmd      (req_chan.cmd),
   .req_row_sel  (req_chan.row_sel),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_a    (rsp_chan.out_a),
   .rsp_out_b    (rsp_chan.out_b),
   .rsp_out_c    (rsp_chan.out_c),
   .rsp_overflow (rsp_chan.overflow)
);
`default_nettype wire
